// ----- src/fp8bsd_pkg.sv -----
// package for the fp8 e4m3 block scale decoder
// holds sizes, float32 constants and the element scaling function; no dependencies
package fp8bsd_pkg;

    localparam int unsigned BLOCK_ELEMENTS_DEF     = 128;
    localparam int unsigned MAX_BLOCKS_PER_ROW_DEF = 256;
    localparam int unsigned CFG_W                  = 9;

    localparam logic [31:0] CANON_NAN = 32'h7fc0_0000;
    localparam logic [31:0] POS_INF   = 32'h7f80_0000;

    // element times scale as float32 bits
    function automatic logic [31:0] scale_element(input logic [7:0] elem,
                                                  input logic [7:0] scale);
        logic        sgn;
        logic [3:0]  ex;
        logic [2:0]  man;
        logic [3:0]  sig;
        logic [1:0]  top;
        logic signed [10:0] k;
        logic signed [10:0] u;
        logic signed [10:0] sh;
        logic [3:0]  r;
        logic [3:0]  q;
        logic [3:0]  rem;
        logic [7:0]  half;
        logic [31:0] res;
        sgn  = elem[7];
        ex   = elem[6:3];
        man  = elem[2:0];
        sig  = (ex != 4'd0) ? {1'b1, man} : {1'b0, man};
        top  = sig[3] ? 2'd3 : sig[2] ? 2'd2 : sig[1] ? 2'd1 : 2'd0;
        k    = ((ex != 4'd0) ? ($signed({7'd0, ex}) - 11'sd10) : -11'sd9)
               + $signed({3'd0, scale}) - 11'sd127;
        u    = k + $signed({9'd0, top});
        sh   = k + 11'sd149;
        r    = 4'd0;
        q    = 4'd0;
        rem  = 4'd0;
        half = 8'd0;
        res  = {sgn, 31'd0};
        if (elem[6:0] == 7'h7f) begin
            res = CANON_NAN;
        end else if (scale == 8'hff) begin
            res = (sig == 4'd0) ? CANON_NAN : (POS_INF | {sgn, 31'd0});
        end else if (sig == 4'd0) begin
            res = {sgn, 31'd0};
        end else if (u > 11'sd127) begin
            res = POS_INF | {sgn, 31'd0};
        end else if (u >= -11'sd126) begin
            res = {sgn, 8'(u + 11'sd127), 23'((28'(sig) << (5'd23 - 5'(top))))};
        end else if (sh >= 11'sd0) begin
            res = {sgn, 31'((31'(sig)) << ((sh > 11'sd22) ? 5'd22 : 5'(sh)))};
        end else if (sh < -11'sd8) begin
            res = {sgn, 31'd0};
        end else begin
            r    = 4'(-sh);
            q    = sig >> r;
            rem  = sig & 4'((5'd1 << r) - 5'd1);
            half = 8'(9'd1 << (r - 4'd1));
            if ({4'd0, rem} > half || ({4'd0, rem} == half && q[0])) begin
                q = q + 4'd1;
            end
            res = {sgn, 27'd0, q};
        end
        return res;
    endfunction

endpackage

// ----- src/fp8_e4m3_block_scale_decoder_core.sv -----
// top level of the fp8 e4m3 block scale decoder
// uses fp8bsd_pkg for sizes and the element scaling function
// the result of an accepted element byte is registered and appears on the output in the next cycle
// throughput: one byte per cycle while o_stall is low; a scale byte gives no result
// the output register is a single stage: input stalls only when it holds an
// untaken item and the output is stalled
// reset (synchronous, active low) sets blocks_per_row to 1 and expects a scale byte
module fp8_e4m3_block_scale_decoder_core
    import fp8bsd_pkg::*;
#(
    parameter int unsigned BLOCK_ELEMENTS     = BLOCK_ELEMENTS_DEF,
    parameter int unsigned MAX_BLOCKS_PER_ROW = MAX_BLOCKS_PER_ROW_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_data_byte,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [31:0]      o_value_bits,
    output logic             o_last_in_row
);

    localparam int unsigned POS_W = $clog2(BLOCK_ELEMENTS + 1);
    localparam int unsigned BLK_W = $clog2(MAX_BLOCKS_PER_ROW + 1);

    logic [BLK_W-1:0] r_bpr, n_bpr;
    logic [7:0]       r_scale;
    logic [POS_W-1:0] r_pos;
    logic [BLK_W-1:0] r_blk;
    logic             r_valid;
    logic [31:0]      r_value;
    logic             r_last;
    logic             w_accept;
    logic             w_eob;
    logic             w_last;

    assign o_stall       = r_valid && i_stall;
    assign w_accept      = i_valid && !o_stall;
    assign o_valid       = r_valid;
    assign o_value_bits  = r_value;
    assign o_last_in_row = r_last;

    // register write with clamping
    always_comb begin
        if (i_cfg_data == '0) begin
            n_bpr = BLK_W'(1);
        end else if (32'(i_cfg_data) > MAX_BLOCKS_PER_ROW) begin
            n_bpr = BLK_W'(MAX_BLOCKS_PER_ROW);
        end else begin
            n_bpr = BLK_W'(i_cfg_data);
        end
    end

    // end of block and end of row
    assign w_eob  = (32'(r_pos) >= BLOCK_ELEMENTS);
    assign w_last = w_eob && ((32'(r_blk) + 32'd1) >= 32'(r_bpr));

    // counters and scale
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpr <= BLK_W'(1);
            r_pos <= '0;
            r_blk <= '0;
            r_scale <= '0;
        end else begin
            if (i_cfg_we) begin
                r_bpr <= n_bpr;
            end
            if (w_accept) begin
                if (r_pos == '0) begin
                    r_scale <= i_data_byte;
                    r_pos   <= POS_W'(1);
                end else if (w_eob) begin
                    r_pos <= '0;
                    r_blk <= w_last ? '0 : r_blk + BLK_W'(1);
                end else begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= (r_pos != '0);
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && r_pos != '0) begin
            r_value <= scale_element(i_data_byte, r_scale);
            r_last  <= w_last;
        end
    end

endmodule

// ----- verif/tb_top.sv -----
// testbench for fp8_e4m3_block_scale_decoder_core: byte stream in, float32 results out
// self-checking against an in-bench scaling predictor; depends on the rtl and fp8bsd_pkg
`timescale 1ns / 1ps
module tb_top;
    import fp8bsd_pkg::*;

    localparam int BLK_ELEMS   = 128;
    localparam int MAX_BLOCKS  = 256;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [31:0] F32_NAN  = 32'h7fc0_0000;
    localparam logic [31:0] F32_INF  = 32'h7f80_0000;

    typedef struct packed {
        logic [31:0] bits;
        logic        last;
    } scaled_value_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             i_valid = 1'b0;
    logic [7:0]       i_data_byte = 8'd0;
    logic             i_stall = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic [31:0]      o_value_bits;
    logic             o_last_in_row;

    fp8_e4m3_block_scale_decoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_value_bits  (o_value_bits),
        .o_last_in_row (o_last_in_row)
    );

    always #2 i_clk = ~i_clk;

    // stimulus and expectation stores
    logic [7:0]    pending_bytes[$];
    scaled_value_t expected_values[$];
    bit            idle_on = 1'b1;
    int            accept_cnt = 0;
    int            n_results = 0;
    int            n_rows = 0;
    int            n_mismatch = 0;
    int            cycle_cnt = 0;

    // predictor state
    int            row_blocks = 1;
    logic [7:0]    cur_scale = 8'd0;
    int            pos_in_block = 0;
    int            block_idx = 0;

    // element times block scale as float32 bits
    function automatic logic [31:0] e4m3_times_e8m0(logic [7:0] elem, logic [7:0] scale);
        logic [31:0] sgn;
        int          ex, sig, msb, expo, unb, sh, r, q, rem, half;
        sgn = elem[7] ? 32'h8000_0000 : 32'd0;
        if (elem[6:0] == 7'h7f) return F32_NAN;
        ex  = elem[6:3];
        sig = (ex != 0) ? 8 + elem[2:0] : elem[2:0];
        if (scale == 8'hff) return (sig == 0) ? F32_NAN : (sgn | F32_INF);
        if (sig == 0) return sgn;
        // value is sig * 2^expo
        expo = ((ex != 0) ? ex - 10 : -9) + int'(scale) - 127;
        msb  = (sig >= 8) ? 3 : (sig >= 4) ? 2 : (sig >= 2) ? 1 : 0;
        unb  = msb + expo;
        if (unb > 127) return sgn | F32_INF;
        if (unb >= -126)
            return sgn | (32'(unb + 127) << 23) | ((32'(sig) << (23 - msb)) & 32'h007f_ffff);
        // subnormal range, units of 2^-149
        sh = expo + 149;
        if (sh >= 0) return sgn | (32'(sig) << sh);
        r = -sh;
        if (r > 8) return sgn;
        q    = sig >> r;
        rem  = sig - (q << r);
        half = 1 << (r - 1);
        if (rem > half || (rem == half && q[0])) q++;
        return sgn | 32'(q);
    endfunction

    // sender: one item per handshake, with random gaps when idle_on is set
    int tx_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) accept_cnt <= accept_cnt + 1;
            if (tx_gap > 0) begin
                tx_gap  <= tx_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                i_valid     <= 1'b1;
                i_data_byte <= pending_bytes.pop_front();
                tx_gap      <= idle_on ? $urandom_range(0, 10) : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall: random waits when idle_on is set, plus one long hold-off
    int rx_wait = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (!hold_done && accept_cnt >= 300) begin
            hold_done <= 1'b1;
            hold_left <= 250;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= (hold_left > 1);
        end else if (o_valid && !i_stall) begin
            int w;
            w = idle_on ? $urandom_range(0, 10) : 0;
            rx_wait <= w;
            i_stall <= (w != 0);
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            i_stall <= (rx_wait > 1);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // check results, then track config and predict accepted items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_blocks   = 1;
            cur_scale    = 8'd0;
            pos_in_block = 0;
            block_idx    = 0;
        end else begin
            if (o_valid && !i_stall) begin
                n_results++;
                if (o_last_in_row) n_rows++;
                if (expected_values.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected result bits=%h last=%b", o_value_bits,
                                 o_last_in_row);
                end else begin
                    scaled_value_t exp_v;
                    exp_v = expected_values.pop_front();
                    if (exp_v.bits !== o_value_bits || exp_v.last !== o_last_in_row) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("mismatch: expected bits=%h last=%b, got bits=%h last=%b",
                                     exp_v.bits, exp_v.last, o_value_bits, o_last_in_row);
                    end
                end
            end
            if (i_cfg_we) begin
                row_blocks = (i_cfg_data == 0) ? 1 :
                             (int'(i_cfg_data) > MAX_BLOCKS) ? MAX_BLOCKS : int'(i_cfg_data);
            end
            if (i_valid && !o_stall) begin
                if (pos_in_block == 0) begin
                    cur_scale    = i_data_byte;
                    pos_in_block = 1;
                end else begin
                    scaled_value_t v;
                    bit end_blk;
                    end_blk = (pos_in_block >= BLK_ELEMS);
                    v.bits  = e4m3_times_e8m0(i_data_byte, cur_scale);
                    v.last  = end_blk && (block_idx + 1 >= row_blocks);
                    expected_values.push_back(v);
                    if (end_blk) begin
                        pos_in_block = 0;
                        block_idx    = v.last ? 0 : block_idx + 1;
                    end else begin
                        pos_in_block++;
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("[fp8_e4m3_block_scale_decoder_core] ERROR");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || i_valid || expected_values.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_row_blocks(logic [CFG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // scale byte, then given elements, then random fill up to a block
    task automatic push_block(logic [7:0] scale, logic [7:0] elems[$]);
        pending_bytes.push_back(scale);
        for (int i = 0; i < BLK_ELEMS; i++)
            pending_bytes.push_back(i < elems.size() ? elems[i] : 8'($urandom_range(0, 255)));
    endtask

    task automatic push_random_bytes(int n);
        for (int i = 0; i < n; i++) pending_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    initial begin
        logic [7:0] edge_elems[$];
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero count is read as one row block
        write_row_blocks(9'd0);
        edge_elems = '{8'h00, 8'h80, 8'h7f, 8'hff, 8'h01, 8'h81, 8'h07, 8'h08,
                       8'h7e, 8'hfe, 8'h38, 8'hb8, 8'h77};
        // infinite scale: zero gives nan, other non-nan elements give signed infinity
        push_block(8'd255, edge_elems);
        wait_idle();

        // two blocks per row without idling: subnormal range, then overflow
        idle_on = 1'b0;
        write_row_blocks(9'd2);
        push_block(8'd0, edge_elems);
        push_block(8'd254, edge_elems);
        wait_idle();

        // count above the maximum saturates: start of a long row, unit scale
        idle_on = 1'b1;
        write_row_blocks(9'h1ff);
        pending_bytes.push_back(8'd127);
        foreach (edge_elems[i]) pending_bytes.push_back(edge_elems[i]);
        push_random_bytes(46);
        wait_idle();
        repeat (10) @(posedge i_clk);

        $display("covered %0d input bytes, %0d element results, %0d row ends",
                 accept_cnt, n_results, n_rows);
        $display("row sizes 1 and 2 plus a saturated row start; %0d mismatches", n_mismatch);
        if (n_mismatch == 0) begin
            $display("[fp8_e4m3_block_scale_decoder_core] OK");
        end else begin
            $display("[fp8_e4m3_block_scale_decoder_core] ERROR");
        end
        $finish;
    end

endmodule
